// File: hw/rtl/stc_pkg.sv
// Shared constants, tables and types of the Taylor-series sine core.
// Used by every module of the block; depends on nothing else.
package stc_pkg;

    localparam int MAX_TERMS   = 12;
    localparam int FRAC_BITS   = 28;
    localparam int TBL_LAST    = 16;
    localparam int KW          = $clog2(MAX_TERMS + 1);
    localparam int TIW         = $clog2(TBL_LAST + 1);
    localparam int CAP_BITS    = 62;
    localparam int TERM_CW     = 4;

    localparam logic [TERM_CW-1:0] TERM_COUNT_RESET = 4'd6;
    localparam logic [63:0]        CAP_MAG          = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [64:0]        TWO_64           = 65'h1_0000_0000_0000_0000;

    // Divisor (2k-2)(2k-1) of term k, and floor(2^64 / divisor), for k >= 2; entries 0 and 1 are unused.
    localparam logic [9:0] DIV_TBL [0:TBL_LAST] = '{
        10'd1, 10'd1, 10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
        10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812, 10'd930
    };

    localparam logic [63:0] RECIP_TBL [0:TBL_LAST] = '{
        64'd0, 64'd0,
        64'(TWO_64 / 65'd6),   64'(TWO_64 / 65'd20),  64'(TWO_64 / 65'd42),
        64'(TWO_64 / 65'd72),  64'(TWO_64 / 65'd110), 64'(TWO_64 / 65'd156),
        64'(TWO_64 / 65'd210), 64'(TWO_64 / 65'd272), 64'(TWO_64 / 65'd342),
        64'(TWO_64 / 65'd420), 64'(TWO_64 / 65'd506), 64'(TWO_64 / 65'd600),
        64'(TWO_64 / 65'd702), 64'(TWO_64 / 65'd812), 64'(TWO_64 / 65'd930)
    };

    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] sine_value;
        logic               saturated;
    } stc_res_t;

endpackage

// File: hw/rtl/stc_if.sv
// Valid/ready channel interfaces for the angle input and the sine result.
// Stand-alone; no package is needed.
interface stc_angle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

interface stc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sine_value;
    logic               saturated;

    modport source (output valid, output sine_value, output saturated, input ready);
    modport sink (input valid, input sine_value, input saturated, output ready);
endinterface

// File: hw/rtl/stc_mul.sv
// Shared 64 x 64 bit unsigned multiplier built from one 32 x 32 bit unit.
// Depends on stc_pkg for the request and response types.
module stc_mul
    import stc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  prod_reg;
    logic         pv_reg;
    logic [1:0]   psel_reg;
    logic [127:0] sum_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] prod_shifted;

    assign a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (psel_reg)
            2'd0:    prod_shifted = {64'd0, prod_reg};
            2'd3:    prod_shifted = {prod_reg, 64'd0};
            default: prod_shifted = {32'd0, prod_reg, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd4;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pv_reg && (psel_reg == 2'd3);
            if (req.start)
            begin
                cnt_reg <= 3'd0;
                pv_reg  <= 1'b0;
            end
            else if (!cnt_reg[2])
            begin
                cnt_reg <= cnt_reg + 3'd1;
                pv_reg  <= 1'b1;
            end
            else
            begin
                pv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.op_a;
            b_reg   <= req.op_b;
            sum_reg <= '0;
        end
        else
        begin
            if (!cnt_reg[2])
            begin
                prod_reg <= 64'(a_half) * 64'(b_half);
                psel_reg <= cnt_reg[1:0];
            end
            if (pv_reg)
            begin
                sum_reg <= sum_reg + prod_shifted;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = sum_reg;

endmodule

// File: hw/rtl/stc_seq.sv
// Sequencer and term datapath of the Taylor-series sine core.
// Depends on stc_pkg and the angle channel interface; drives the shared multiplier.
module stc_seq
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    stc_angle_if.sink            angle_ch,
    input  logic [TERM_CW-1:0]   term_count,
    output mul_req_t             mul_req,
    input  mul_rsp_t             mul_rsp,
    output stc_res_t             res,
    input  logic                 res_ready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_MT   = 7'b0000100,
        S_MR   = 7'b0001000,
        S_MC   = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } seq_state_t;

    localparam logic signed [63:0] CAP_POS = CAP_MAG;
    localparam logic signed [63:0] CAP_NEG = -CAP_POS;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    seq_state_t         state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      n_reg, n_next;
    logic               xneg_reg, xneg_next;
    logic [63:0]        a2_reg, a2_next;
    logic [63:0]        t_reg, t_next;
    logic [61:0]        r_reg, r_next;
    logic [61:0]        q_reg, q_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               ovfneg_reg, ovfneg_next;

    logic [31:0]        mag_in;
    logic               neg_k;
    logic signed [63:0] acc_sum;
    logic [TIW-1:0]     tidx;
    logic [61:0]        rem;
    logic [61:0]        q0;
    logic [61:0]        r_new;

    assign mag_in = angle_ch.angle[31] ? 32'(-angle_ch.angle) : 32'(angle_ch.angle);
    assign neg_k  = xneg_reg ^ ~k_reg[0];
    assign tidx   = TIW'(k_reg);
    assign acc_sum = neg_k ? acc_reg - $signed(t_reg) : acc_reg + $signed(t_reg);
    assign rem    = r_reg - mul_rsp.product[61:0];
    assign q0     = mul_rsp.product[64 +: 62];
    assign r_new  = mul_rsp.product[FRAC_BITS +: 62];

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        xneg_next   = xneg_reg;
        a2_next     = a2_reg;
        t_next      = t_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        ovfneg_next = ovfneg_reg;
        mul_req     = '0;
        res         = '0;
        angle_ch.ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                angle_ch.ready = 1'b1;
                if (angle_ch.valid)
                begin
                    xneg_next   = angle_ch.angle[31];
                    t_next      = 64'(mag_in);
                    acc_next    = '0;
                    ovf_next    = 1'b0;
                    ovfneg_next = 1'b0;
                    k_next      = KW'(1);
                    n_next      = (5'(term_count) > 5'(MAX_TERMS)) ? KW'(MAX_TERMS)
                                                                  : KW'(term_count);
                    mul_req.start = 1'b1;
                    mul_req.op_a  = 64'(mag_in);
                    mul_req.op_b  = 64'(mag_in);
                    state_next    = S_SQ;
                end
            end
            S_SQ:
            begin
                if (mul_rsp.done)
                begin
                    a2_next    = 64'(mul_rsp.product >> FRAC_BITS);
                    state_next = (n_reg == '0) ? S_OUT : S_ADD;
                end
            end
            S_ADD:
            begin
                if (acc_sum > CAP_POS)
                begin
                    acc_next    = CAP_POS;
                    ovf_next    = 1'b1;
                    ovfneg_next = 1'b0;
                end
                else if (acc_sum < CAP_NEG)
                begin
                    acc_next    = CAP_NEG;
                    ovf_next    = 1'b1;
                    ovfneg_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_sum;
                end
                if (k_reg == n_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    k_next        = k_reg + KW'(1);
                    mul_req.start = 1'b1;
                    mul_req.op_a  = t_reg;
                    mul_req.op_b  = a2_reg;
                    state_next    = S_MT;
                end
            end
            S_MT:
            begin
                if (mul_rsp.done)
                begin
                    if ((mul_rsp.product >> (CAP_BITS + FRAC_BITS)) != '0)
                    begin
                        t_next      = CAP_MAG;
                        ovf_next    = 1'b1;
                        ovfneg_next = neg_k;
                        state_next  = S_ADD;
                    end
                    else
                    begin
                        r_next        = r_new;
                        mul_req.start = 1'b1;
                        mul_req.op_a  = 64'(r_new);
                        mul_req.op_b  = RECIP_TBL[tidx];
                        state_next    = S_MR;
                    end
                end
            end
            S_MR:
            begin
                if (mul_rsp.done)
                begin
                    q_next        = q0;
                    mul_req.start = 1'b1;
                    mul_req.op_a  = 64'(q0);
                    mul_req.op_b  = 64'(DIV_TBL[tidx]);
                    state_next    = S_MC;
                end
            end
            S_MC:
            begin
                if (mul_rsp.done)
                begin
                    t_next     = (rem >= 62'(DIV_TBL[tidx])) ? 64'(q_reg + 62'd1)
                                                             : 64'(q_reg);
                    state_next = S_ADD;
                end
            end
            S_OUT:
            begin
                res.valid = 1'b1;
                if (ovf_reg)
                begin
                    res.saturated  = 1'b1;
                    res.sine_value = ovfneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else if (acc_reg > I32_MAX)
                begin
                    res.saturated  = 1'b1;
                    res.sine_value = 32'sh7FFF_FFFF;
                end
                else if (acc_reg < I32_MIN)
                begin
                    res.saturated  = 1'b1;
                    res.sine_value = 32'sh8000_0000;
                end
                else
                begin
                    res.sine_value = acc_reg[31:0];
                end
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xneg_reg   <= xneg_next;
        a2_reg     <= a2_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        acc_reg    <= acc_next;
        ovf_reg    <= ovf_next;
        ovfneg_reg <= ovfneg_next;
    end

endmodule

// File: hw/rtl/sine_taylor_series_core.sv
// Top level of the Taylor-series sine core: term-count register, sequencer,
// shared multiplier and result register. Depends on stc_pkg, stc_if, stc_mul, stc_seq.

// Each transfer on angle_ch carries a signed Q3.28 angle; the core returns one
// transfer on result_ch holding the saturated Q3.28 partial Maclaurin sum and a
// flag that is set when the sum was clipped. The core works on one angle at a
// time and all arithmetic runs through a single 32 x 32 bit multiplier that builds
// each 64-bit product from four partial products, and a term that overflows
// skips the division by its divisor. A finished result waits in its own register,
// so the next angle may be taken while it is still unclaimed. The term count is
// sampled when an angle is accepted; values above twelve act as twelve.
module sine_taylor_series_core
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TERM_CW-1:0] cfg_wdata,
    stc_angle_if.sink          angle_ch,
    stc_result_if.source       result_ch
);

    logic [TERM_CW-1:0] term_count_reg;
    logic               out_valid_reg;
    logic signed [31:0] sine_value_reg;
    logic               saturated_reg;
    logic               res_ready;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    stc_res_t           seq_res;

    stc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    stc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle_ch   (angle_ch),
        .term_count (term_count_reg),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .res        (seq_res),
        .res_ready  (res_ready)
    );

    assign res_ready = !out_valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                term_count_reg <= cfg_wdata;
            end
            if (seq_res.valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res.valid && res_ready)
        begin
            sine_value_reg <= seq_res.sine_value;
            saturated_reg  <= seq_res.saturated;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sine_value = sine_value_reg;
    assign result_ch.saturated  = saturated_reg;

    // Every multiplier answer follows a matching start.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> $past(mul_req.start, 6))
        else $error("multiplier result without a matching start");

    // No new product is started on the cycle after a start.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |=> !mul_req.start)
        else $error("multiplier restarted while busy");

    // The core is not ready for a new angle in the cycle after it accepts one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (angle_ch.valid && angle_ch.ready) |=> !angle_ch.ready)
        else $error("angle accepted while a previous one is in work");

    // A result handed over by the sequencer is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_res.valid && res_ready) |=> out_valid_reg)
        else $error("result lost between sequencer and output register");

endmodule
